// ===== sv/ypcb_pkg.sv =====
// ----------------------------------------------------------------------------
// ypcb_pkg: types, constants and sine table for the yaw/pitch camera basis
// Fixed formats, reset values of the camera, and the shared rounding,
// saturation and sine lookup functions.
// ----------------------------------------------------------------------------
package ypcb_pkg;

	localparam int ANGLE_BITS       = 16;
	localparam int UNIT_FRAC_BITS   = 14;
	localparam int POS_FRAC_BITS    = 16;
	localparam int SINE_TABLE_DEPTH = 1024;

	// log2 of the largest power of two not above the table depth, at least four entries
	function automatic int calc_tab_bits();
		int b;
		b = 0;
		for (int k = 0; k < 30; k++) begin
			if ((longint'(2) << b) <= longint'(SINE_TABLE_DEPTH))
				b++;
		end
		if (b < 2)
			b = 2;
		return b;
	endfunction

	localparam int TAB_BITS = calc_tab_bits();
	localparam int QTR      = 1 << (TAB_BITS - 2);
	localparam int UNIT_W   = UNIT_FRAC_BITS + 2;
	localparam int VEC_W    = 16;
	localparam int POS_W    = 32;
	localparam int PSUM_W   = UNIT_W + POS_W + 2;

	typedef logic [ANGLE_BITS-1:0]        angle_t;
	typedef logic [TAB_BITS-1:0]          tab_idx_t;
	typedef logic [TAB_BITS-3:0]          qtr_idx_t;
	typedef logic [UNIT_FRAC_BITS:0]      umag_t;
	typedef logic signed [UNIT_W-1:0]     unit_t;
	typedef logic signed [VEC_W-1:0]      vec_t;
	typedef logic signed [POS_W-1:0]      pos_t;
	typedef logic signed [2*UNIT_W-1:0]   uprod_t;
	typedef logic signed [UNIT_W+POS_W-1:0] pprod_t;
	typedef logic signed [PSUM_W-1:0]     psum_t;

	typedef enum logic [1:0] {
		ACT_MOVE_REL = 2'd0,
		ACT_MOVE_ABS = 2'd1,
		ACT_ROTATE   = 2'd2,
		ACT_SET_ROT  = 2'd3
	} action_t;

	typedef struct packed {
		action_t             action;
		logic signed [31:0]  arg_x;
		logic signed [31:0]  arg_y;
		logic signed [31:0]  arg_z;
		logic signed [15:0]  yaw_arg;
		logic signed [15:0]  pitch_arg;
	} item_t;

	typedef struct packed {
		pos_t pos_x;
		pos_t pos_y;
		pos_t pos_z;
		vec_t front_x;
		vec_t front_y;
		vec_t front_z;
		vec_t right_x;
		vec_t right_y;
		vec_t right_z;
		vec_t up_x;
		vec_t up_y;
		vec_t up_z;
	} result_t;

	// camera state as seen by the vector stage
	typedef struct packed {
		pos_t  pos_x;
		pos_t  pos_y;
		pos_t  pos_z;
		unit_t sy;
		unit_t cy;
		unit_t sp;
		unit_t cp;
	} basis_t;

	localparam pos_t   POS_MAX     = 32'sh7fffffff;
	localparam pos_t   POS_MIN     = 32'sh80000000;
	localparam umag_t  ONE_MAG     = umag_t'(longint'(1) << UNIT_FRAC_BITS);
	localparam uprod_t UPROD_HALF  = uprod_t'(longint'(1) << (UNIT_FRAC_BITS - 1));
	localparam pprod_t PPROD_HALF  = pprod_t'(longint'(1) << (UNIT_FRAC_BITS - 1));

	localparam longint FULL_TURN    = longint'(1) << ANGLE_BITS;
	localparam angle_t QUARTER_TURN = angle_t'(FULL_TURN / 4);
	localparam angle_t RESET_YAW    = angle_t'(3 * (FULL_TURN / 4));
	// minus 30 degrees is one twelfth of a turn, rounded to nearest
	localparam angle_t RESET_PITCH  = angle_t'(FULL_TURN - (FULL_TURN + 6) / 12);

	localparam longint RESET_Y_UNITS = 300;
	localparam longint RESET_Z_UNITS = 600;
	localparam longint RESET_Y_L = RESET_Y_UNITS * (longint'(1) << POS_FRAC_BITS);
	localparam longint RESET_Z_L = RESET_Z_UNITS * (longint'(1) << POS_FRAC_BITS);
	localparam pos_t RESET_X = '0;
	localparam pos_t RESET_Y = (RESET_Y_L > 64'sd2147483647) ? POS_MAX : pos_t'(RESET_Y_L);
	localparam pos_t RESET_Z = (RESET_Z_L > 64'sd2147483647) ? POS_MAX : pos_t'(RESET_Z_L);

	localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

	// sin(pi/2 * r / QTR) by Taylor series in Q30, rounded half up
	function automatic umag_t quarter_sine(input longint unsigned r);
		longint unsigned theta;
		longint unsigned theta2;
		longint unsigned term;
		longint unsigned v;
		longint signed   sum;
		theta  = (PI_HALF_Q30 * r) >> (TAB_BITS - 2);
		theta2 = (theta * theta) >> 30;
		term   = theta;
		sum    = signed'(theta);
		term = ((term * theta2) >> 30) / 64'd6;   sum = sum - signed'(term);
		term = ((term * theta2) >> 30) / 64'd20;  sum = sum + signed'(term);
		term = ((term * theta2) >> 30) / 64'd42;  sum = sum - signed'(term);
		term = ((term * theta2) >> 30) / 64'd72;  sum = sum + signed'(term);
		term = ((term * theta2) >> 30) / 64'd110; sum = sum - signed'(term);
		term = ((term * theta2) >> 30) / 64'd156; sum = sum + signed'(term);
		term = ((term * theta2) >> 30) / 64'd210; sum = sum - signed'(term);
		term = ((term * theta2) >> 30) / 64'd272; sum = sum + signed'(term);
		if (sum < 0)
			sum = 0;
		v = unsigned'(sum);
		if (UNIT_FRAC_BITS < 30)
			v = (v + (64'd1 << (29 - UNIT_FRAC_BITS))) >> (30 - UNIT_FRAC_BITS);
		if (v > (64'd1 << UNIT_FRAC_BITS))
			v = 64'd1 << UNIT_FRAC_BITS;
		return umag_t'(v);
	endfunction

	typedef umag_t qtab_t [QTR];

	function automatic qtab_t build_qtab();
		qtab_t t;
		for (int i = 0; i < QTR; i++)
			t[i] = quarter_sine(longint'(i));
		return t;
	endfunction

	localparam qtab_t QTAB = build_qtab();

	// binary angle to table index, truncating
	function automatic tab_idx_t ang_idx(input angle_t a);
		logic [ANGLE_BITS+TAB_BITS-1:0] w;
		w = {a, {TAB_BITS{1'b0}}};
		return w[ANGLE_BITS+TAB_BITS-1:ANGLE_BITS];
	endfunction

	// 16-bit input angle rescaled to ANGLE_BITS
	function automatic angle_t ang_in(input logic [15:0] raw);
		logic [ANGLE_BITS+15:0] w;
		w = {raw, {ANGLE_BITS{1'b0}}};
		return w[ANGLE_BITS+15:16];
	endfunction

	function automatic unit_t sine_at(input tab_idx_t idx);
		logic [1:0] quad;
		qtr_idx_t   r;
		qtr_idx_t   r_n;
		umag_t      m;
		unit_t      s;
		quad = idx[TAB_BITS-1 -: 2];
		r    = idx[TAB_BITS-3:0];
		r_n  = -r;
		if (quad[0])
			m = (r == '0) ? ONE_MAG : QTAB[r_n];
		else
			m = QTAB[r];
		s = unit_t'({1'b0, m});
		return quad[1] ? -s : s;
	endfunction

	function automatic unit_t cosine_at(input tab_idx_t idx);
		return sine_at(idx + tab_idx_t'(QTR));
	endfunction

	// product of two unit values, rounded half away from zero
	function automatic unit_t mul_unit(input unit_t a, input unit_t b);
		uprod_t              p;
		logic [2*UNIT_W-1:0] mag;
		logic                neg;
		p   = a * b;
		neg = p[2*UNIT_W-1];
		mag = neg ? -p : p;
		mag = (mag + UPROD_HALF) >> UNIT_FRAC_BITS;
		return neg ? -unit_t'(mag) : unit_t'(mag);
	endfunction

	// unit value times Q16.16 velocity, rounded half away from zero
	function automatic pprod_t mul_pos(input unit_t a, input pos_t b);
		pprod_t                    p;
		logic [UNIT_W+POS_W-1:0]   mag;
		logic                      neg;
		p   = a * b;
		neg = p[UNIT_W+POS_W-1];
		mag = neg ? -p : p;
		mag = (mag + PPROD_HALF) >> UNIT_FRAC_BITS;
		return neg ? -pprod_t'(mag) : pprod_t'(mag);
	endfunction

	function automatic pos_t sat_pos(input psum_t v);
		logic [PSUM_W-32:0] hi;
		hi = v[PSUM_W-1:31];
		if (hi == '0 || hi == '1)
			return pos_t'(v[31:0]);
		else if (v[PSUM_W-1])
			return POS_MIN;
		else
			return POS_MAX;
	endfunction

	function automatic vec_t to_vec(input unit_t v);
		logic signed [UNIT_W+VEC_W-1:0] w;
		w = (UNIT_W + VEC_W)'(v);
		return vec_t'(w[VEC_W-1:0]);
	endfunction

	localparam unit_t RESET_SY = sine_at(ang_idx(RESET_YAW));
	localparam unit_t RESET_CY = cosine_at(ang_idx(RESET_YAW));
	localparam unit_t RESET_SP = sine_at(ang_idx(RESET_PITCH));
	localparam unit_t RESET_CP = cosine_at(ang_idx(RESET_PITCH));

endpackage

// ===== sv/ypcb_state.sv =====
// ----------------------------------------------------------------------------
// ypcb_state: camera state update
// Applies one item to position and angles and looks up the sine and cosine
// of the new angles, all held as state for the next item.
// ----------------------------------------------------------------------------
module ypcb_state
	import ypcb_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   fire,
	input  item_t  item,
	output basis_t basis
);

	angle_t yaw_q, pitch_q;
	pos_t   pos_x_q, pos_y_q, pos_z_q;
	unit_t  sy_q, cy_q, sp_q, cp_q;

	angle_t   ya, pa, yaw_n, pitch_n;
	pos_t     pos_x_n, pos_y_n, pos_z_n;
	unit_t    rx_coef, rz_coef;
	tab_idx_t yaw_idx, pitch_idx;

	assign ya = ang_in(item.yaw_arg);
	assign pa = ang_in(item.pitch_arg);

	// right vector flips with the sign of cos(pitch); zero counts as positive
	assign rx_coef = cp_q[UNIT_W-1] ? sy_q : -sy_q;
	assign rz_coef = cp_q[UNIT_W-1] ? -cy_q : cy_q;

	always_comb begin
		yaw_n   = yaw_q;
		pitch_n = pitch_q;
		pos_x_n = pos_x_q;
		pos_y_n = pos_y_q;
		pos_z_n = pos_z_q;
		unique case (item.action)
			ACT_MOVE_REL: begin
				pos_x_n = sat_pos(psum_t'(pos_x_q) + psum_t'(mul_pos(rx_coef, item.arg_x))
					+ psum_t'(mul_pos(cy_q, item.arg_z)));
				pos_y_n = sat_pos(psum_t'(pos_y_q) + psum_t'(item.arg_y));
				pos_z_n = sat_pos(psum_t'(pos_z_q) + psum_t'(mul_pos(rz_coef, item.arg_x))
					+ psum_t'(mul_pos(sy_q, item.arg_z)));
			end
			ACT_MOVE_ABS: begin
				pos_x_n = item.arg_x;
				pos_y_n = item.arg_y;
				pos_z_n = item.arg_z;
			end
			ACT_ROTATE: begin
				yaw_n   = yaw_q + ya;
				pitch_n = pitch_q + pa;
			end
			ACT_SET_ROT: begin
				yaw_n   = ya - QUARTER_TURN;
				pitch_n = pa;
			end
			default: begin
				yaw_n = yaw_q;
			end
		endcase
	end

	assign yaw_idx   = ang_idx(yaw_n);
	assign pitch_idx = ang_idx(pitch_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_q   <= RESET_YAW;
			pitch_q <= RESET_PITCH;
			pos_x_q <= RESET_X;
			pos_y_q <= RESET_Y;
			pos_z_q <= RESET_Z;
			sy_q    <= RESET_SY;
			cy_q    <= RESET_CY;
			sp_q    <= RESET_SP;
			cp_q    <= RESET_CP;
		end else if (fire) begin
			yaw_q   <= yaw_n;
			pitch_q <= pitch_n;
			pos_x_q <= pos_x_n;
			pos_y_q <= pos_y_n;
			pos_z_q <= pos_z_n;
			sy_q    <= sine_at(yaw_idx);
			cy_q    <= cosine_at(yaw_idx);
			sp_q    <= sine_at(pitch_idx);
			cp_q    <= cosine_at(pitch_idx);
		end
	end

	assign basis.pos_x = pos_x_q;
	assign basis.pos_y = pos_y_q;
	assign basis.pos_z = pos_z_q;
	assign basis.sy    = sy_q;
	assign basis.cy    = cy_q;
	assign basis.sp    = sp_q;
	assign basis.cp    = cp_q;

endmodule

// ===== sv/ypcb_vec.sv =====
// ----------------------------------------------------------------------------
// ypcb_vec: basis vectors and result register
// Forms front, right and up from the held sine and cosine values and
// registers them with the position.
// ----------------------------------------------------------------------------
module ypcb_vec
	import ypcb_pkg::*;
(
	input  logic    clk,
	input  logic    load,
	input  basis_t  basis,
	output result_t result
);

	result_t result_q;
	result_t result_d;
	logic    neg;
	unit_t   cy_cp, sy_cp, cy_sp, sy_sp;

	assign neg   = basis.cp[UNIT_W-1];
	assign cy_cp = mul_unit(basis.cy, basis.cp);
	assign sy_cp = mul_unit(basis.sy, basis.cp);
	assign cy_sp = mul_unit(basis.cy, basis.sp);
	assign sy_sp = mul_unit(basis.sy, basis.sp);

	always_comb begin
		result_d.pos_x   = basis.pos_x;
		result_d.pos_y   = basis.pos_y;
		result_d.pos_z   = basis.pos_z;
		result_d.front_x = to_vec(cy_cp);
		result_d.front_y = to_vec(basis.sp);
		result_d.front_z = to_vec(sy_cp);
		result_d.right_x = to_vec(neg ? basis.sy : -basis.sy);
		result_d.right_y = '0;
		result_d.right_z = to_vec(neg ? -basis.cy : basis.cy);
		// up = right x front
		result_d.up_x    = to_vec(neg ? cy_sp : -cy_sp);
		result_d.up_y    = to_vec(neg ? -basis.cp : basis.cp);
		result_d.up_z    = to_vec(neg ? sy_sp : -sy_sp);
	end

	always_ff @(posedge clk) begin
		if (load)
			result_q <= result_d;
	end

	assign result = result_q;

endmodule

// ===== sv/yaw_pitch_camera_basis.sv =====
// ----------------------------------------------------------------------------
// yaw_pitch_camera_basis: fly camera with yaw/pitch binary angles
// Moves and rotates a camera per item and returns its position and its
// front, right and up vectors.
// ----------------------------------------------------------------------------
//   channel   payload    handshake                  direction
//   item      item_t     item_valid / item_stall    in
//   result    result_t   result_valid / result_stall out
//
// One item per cycle sustained while result_stall is low; the state update
// (angle add, table lookup, position multiply-add) closes its loop through
// the state registers. A transfer passes the input register, the state
// update and the vector products into the result register, where it is valid.
// Reset puts the camera at (0, 300, 600) facing yaw -90, pitch -30 degrees.
// result_stall holds the result register and backs up through the update
// stage and input register; bubbles are filled, so no cycle is lost.
// ----------------------------------------------------------------------------
module yaw_pitch_camera_basis
	import ypcb_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic   valid_s1, valid_s2, res_valid_q;
	item_t  item_s1;
	logic   upd_fire, res_load;
	basis_t basis;

	assign res_load   = valid_s2 && (!res_valid_q || !result_stall);
	assign upd_fire   = valid_s1 && (!valid_s2 || res_load);
	assign item_stall = valid_s1 && !upd_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (!item_stall)
				valid_s1 <= item_valid;
			if (upd_fire)
				valid_s2 <= 1'b1;
			else if (res_load)
				valid_s2 <= 1'b0;
			if (res_load)
				res_valid_q <= 1'b1;
			else if (!result_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall)
			item_s1 <= item;
	end

	ypcb_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (upd_fire),
		.item   (item_s1),
		.basis  (basis)
	);

	ypcb_vec u_vec (
		.clk    (clk),
		.load   (res_load),
		.basis  (basis),
		.result (result)
	);

	assign result_valid = res_valid_q;

`ifndef NO_ASSERTIONS
	// an accepted transfer always lands in the input register
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> valid_s1)
		else $error("accepted item not held in input register");

	a_update_s2: assert property (@(posedge clk) disable iff (!arst_n)
		upd_fire |=> valid_s2)
		else $error("state update lost before vector stage");

	// camera state must not move under a result that is still pending
	a_basis_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_load |=> $stable(basis))
		else $error("camera state changed under a pending result");

	a_right_y_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.right_y == '0)
		else $error("right vector has a vertical component");
`endif

endmodule
